>>> src/ole_pkg.sv
package ole_pkg;

  localparam int DEPTH   = 16;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int CMD_W   = 3;
  localparam int VAL_W   = 32;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  localparam logic [CMD_W-1:0] CMD_INSERT    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DEL_FIRST = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DEL_LAST  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DEL_VALUE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DUMP      = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd3;

  // per-cycle move applied along the cell chain
  typedef struct packed {
    logic ins;      // every cell takes its left neighbor, cell 0 takes the new value
    logic del_all;  // every cell takes its right neighbor
    logic del_hit;  // cells at and after the first match take their right neighbor
    logic rot;      // rotate left within the list, tail takes the head
  } ole_ctl_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DUMP = 2'b10
  } ole_state_t;

endpackage

>>> src/ordered_list_engine_core.sv
// Bounded list of up to DEPTH signed 32-bit values held in a chain of cells,
// front at cell 0. Insert, delete first, delete last and delete by value each
// return one result beat: every cell compares and shifts in parallel, so the
// whole list moves at once. Dump returns one beat per entry (one beat with
// status empty for an empty list), one per cycle while the output is not
// stalled, by rotating the chain past cell 0; it holds the input stalled until
// the last entry has gone out and leaves the list as it was. A new command is
// taken as soon as the previous result beat is taken or being taken.
module ordered_list_engine_core
  import ole_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [CMD_W-1:0]          in_cmd,
  input  logic signed [VAL_W-1:0]   in_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [STAT_W-1:0]         out_status,
  output logic signed [VAL_W-1:0]   out_item_value,
  output logic [COUNT_W-1:0]        out_count,
  output logic                      out_last
);

  ole_state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] remain_r, remain_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]       status_r, status_nxt;
  logic signed [VAL_W-1:0] item_r, item_nxt;
  logic [COUNT_W-1:0]      ocount_r, ocount_nxt;
  logic                    last_r, last_nxt;

  ole_ctl_t ctl;
  logic signed [VAL_W-1:0] cell_val [DEPTH];
  logic [DEPTH-1:0] hit_chain;
  logic [DEPTH-1:0] hit_first;
  logic [DEPTH-1:0] in_range;
  logic [DEPTH-1:0] is_tail;
  logic signed [VAL_W-1:0] hit_val;
  logic signed [VAL_W-1:0] tail_val;
  logic slot_free;
  logic accept;

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE) || !slot_free;
  assign accept    = in_valid && !in_stall;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic signed [VAL_W-1:0] lv;
      logic signed [VAL_W-1:0] rv;
      logic                    hin;

      assign in_range[g] = CNT_W'(g) < count_r;
      assign is_tail[g]  = CNT_W'(g) == (count_r - CNT_W'(1));

      if (g == 0) begin : g_head
        assign lv  = in_value;
        assign hin = 1'b0;
      end else begin : g_body
        assign lv  = cell_val[g-1];
        assign hin = hit_chain[g-1];
      end

      if (g == DEPTH - 1) begin : g_end
        assign rv = cell_val[g];
      end else begin : g_mid
        assign rv = cell_val[g+1];
      end

      ole_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .left_val  (lv),
        .right_val (rv),
        .head_val  (cell_val[0]),
        .key       (in_value),
        .in_range  (in_range[g]),
        .is_tail   (is_tail[g]),
        .hit_in    (hin),
        .val       (cell_val[g]),
        .hit_out   (hit_chain[g]),
        .hit_first (hit_first[g])
      );
    end
  endgenerate

  // one-hot selects: first match and tail entry
  always_comb begin
    hit_val  = '0;
    tail_val = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit_val  = hit_val  | (hit_first[i] ? cell_val[i] : '0);
      tail_val = tail_val | (is_tail[i]   ? cell_val[i] : '0);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    remain_nxt    = remain_r;
    out_valid_nxt = out_valid_r && out_stall;
    status_nxt    = status_r;
    item_nxt      = item_r;
    ocount_nxt    = ocount_r;
    last_nxt      = last_r;
    ctl           = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          status_nxt    = STAT_OK;
          item_nxt      = '0;
          last_nxt      = 1'b1;
          case (in_cmd)
            CMD_INSERT: begin
              if (count_r == CNT_W'(DEPTH)) begin
                status_nxt = STAT_FULL;
              end else begin
                ctl.ins   = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            CMD_DEL_FIRST: begin
              if (count_r == '0) begin
                status_nxt = STAT_EMPTY;
              end else begin
                ctl.del_all = 1'b1;
                item_nxt    = cell_val[0];
                count_nxt   = count_r - CNT_W'(1);
              end
            end
            CMD_DEL_LAST: begin
              if (count_r == '0) begin
                status_nxt = STAT_EMPTY;
              end else begin
                item_nxt  = tail_val;
                count_nxt = count_r - CNT_W'(1);
              end
            end
            CMD_DEL_VALUE: begin
              if (count_r == '0) begin
                status_nxt = STAT_EMPTY;
              end else if (hit_chain[DEPTH-1]) begin
                ctl.del_hit = 1'b1;
                item_nxt    = hit_val;
                count_nxt   = count_r - CNT_W'(1);
              end else begin
                status_nxt = STAT_NOTFOUND;
              end
            end
            CMD_DUMP: begin
              if (count_r == '0) begin
                status_nxt = STAT_EMPTY;
              end else begin
                out_valid_nxt = 1'b0;
                remain_nxt    = count_r;
                state_nxt     = S_DUMP;
              end
            end
            default: begin
            end
          endcase
          ocount_nxt = COUNT_W'(count_nxt);
        end
      end
      S_DUMP: begin
        if (slot_free) begin
          ctl.rot       = 1'b1;
          out_valid_nxt = 1'b1;
          status_nxt    = STAT_OK;
          item_nxt      = cell_val[0];
          ocount_nxt    = COUNT_W'(count_r);
          last_nxt      = (remain_r == CNT_W'(1));
          remain_nxt    = remain_r - CNT_W'(1);
          if (remain_r == CNT_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      remain_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      remain_r    <= remain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    item_r   <= item_nxt;
    ocount_r <= ocount_nxt;
    last_r   <= last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_item_value = item_r;
  assign out_count      = ocount_r;
  assign out_last       = last_r;

endmodule

>>> src/ole_cell.sv
module ole_cell
  import ole_pkg::*;
(
  input  logic                    clk,
  input  ole_ctl_t                ctl,
  input  logic signed [VAL_W-1:0] left_val,
  input  logic signed [VAL_W-1:0] right_val,
  input  logic signed [VAL_W-1:0] head_val,
  input  logic signed [VAL_W-1:0] key,
  input  logic                    in_range,
  input  logic                    is_tail,
  input  logic                    hit_in,
  output logic signed [VAL_W-1:0] val,
  output logic                    hit_out,
  output logic                    hit_first
);

  logic signed [VAL_W-1:0] entry_r;
  logic signed [VAL_W-1:0] entry_nxt;
  logic                    match;

  assign match     = in_range && (entry_r == key);
  assign hit_first = match && !hit_in;
  assign hit_out   = hit_in || match;
  assign val       = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins) begin
      entry_nxt = left_val;
    end else if (ctl.del_all || (ctl.del_hit && hit_out)) begin
      entry_nxt = right_val;
    end else if (ctl.rot) begin
      entry_nxt = is_tail ? head_val : right_val;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

>>> tb/tb_ordered_list_engine_core.sv
module tb_ordered_list_engine_core;
  import ole_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CMD_W-1:0] CMD_UNUSED_A = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_B = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_C = 3'd7;

  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  localparam int IDLE_LIMIT  = 2000;
  localparam int RAND_ITEMS  = 150;
  localparam int TAIL_CYCLES = 20;

  typedef struct {
    logic [CMD_W-1:0]        cmd;
    logic signed [VAL_W-1:0] value;
  } list_cmd_t;

  typedef struct {
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] item_value;
    logic [COUNT_W-1:0]      count;
    logic                    last;
  } list_beat_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [CMD_W-1:0]        in_cmd = '0;
  logic signed [VAL_W-1:0] in_value = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [STAT_W-1:0]       out_status;
  logic signed [VAL_W-1:0] out_item_value;
  logic [COUNT_W-1:0]      out_count;
  logic                    out_last;

  list_cmd_t               cmd_q[$];
  list_beat_t              beats_due[$];
  logic signed [VAL_W-1:0] held[$];     // shadow of the list, front first

  list_cmd_t next_cmd;
  list_beat_t want;
  logic in_taken = 1'b0;
  int   gap_left = 0;
  int   stall_left = 0;
  int   calm_left = 0;
  int   idle_cycles = 0;
  int   items_queued = 0;
  int   items_taken = 0;
  int   beats_checked = 0;
  int   mismatch_cnt = 0;
  int   full_hits = 0;
  int   dump_cnt = 0;
  int   peak_fill = 0;

  ordered_list_engine_core uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_item_value (out_item_value),
    .out_count      (out_count),
    .out_last       (out_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 20);
  endfunction

  // small pool so that delete by value finds matches often
  function automatic logic signed [VAL_W-1:0] pick_value();
    if ($urandom_range(99) >= 40) return $urandom;
    case ($urandom_range(7))
      0: return '0;
      1: return 32'sd1;
      2: return -32'sd1;
      3: return VAL_MIN;
      4: return VAL_MAX;
      5: return 32'sd7;
      6: return -32'sd100;
      default: return 32'sd12345;
    endcase
  endfunction

  function automatic logic [CMD_W-1:0] pick_cmd(input bit filling);
    int r;
    r = $urandom_range(99);
    if (filling) begin
      if (r < 70) return CMD_INSERT;
      if (r < 75) return CMD_DEL_FIRST;
      if (r < 80) return CMD_DEL_LAST;
      if (r < 88) return CMD_DEL_VALUE;
      if (r < 96) return CMD_DUMP;
    end else begin
      if (r < 15) return CMD_INSERT;
      if (r < 35) return CMD_DEL_FIRST;
      if (r < 55) return CMD_DEL_LAST;
      if (r < 80) return CMD_DEL_VALUE;
      if (r < 94) return CMD_DUMP;
    end
    case ($urandom_range(2))
      0: return CMD_UNUSED_A;
      1: return CMD_UNUSED_B;
      default: return CMD_UNUSED_C;
    endcase
  endfunction

  // update the shadow list for one command and queue the beats it produces
  task automatic apply_list_cmd(input logic [CMD_W-1:0] cmd,
                                input logic signed [VAL_W-1:0] val);
    list_beat_t b;
    int hit;
    b.status = STAT_OK;
    b.item_value = '0;
    b.last = 1'b1;
    hit = -1;
    case (cmd)
      CMD_INSERT: begin
        if (held.size() >= DEPTH) begin
          b.status = STAT_FULL;
          full_hits++;
        end else begin
          held.push_front(val);
        end
      end
      CMD_DEL_FIRST: begin
        if (held.size() == 0) b.status = STAT_EMPTY;
        else b.item_value = held.pop_front();
      end
      CMD_DEL_LAST: begin
        if (held.size() == 0) b.status = STAT_EMPTY;
        else b.item_value = held.pop_back();
      end
      CMD_DEL_VALUE: begin
        if (held.size() == 0) begin
          b.status = STAT_EMPTY;
        end else begin
          for (int i = 0; i < held.size() && hit < 0; i++)
            if (held[i] == val) hit = i;
          if (hit < 0) begin
            b.status = STAT_NOTFOUND;
          end else begin
            b.item_value = held[hit];
            held.delete(hit);
          end
        end
      end
      CMD_DUMP: begin
        dump_cnt++;
        if (held.size() == 0) begin
          b.status = STAT_EMPTY;
        end else begin
          // all but the final entry go out here, the final one below
          for (int i = 0; i < held.size() - 1; i++) begin
            b.item_value = held[i];
            b.count = COUNT_W'(held.size());
            b.last = 1'b0;
            beats_due.push_back(b);
          end
          b.item_value = held[held.size() - 1];
          b.last = 1'b1;
        end
      end
      default: ;
    endcase
    b.count = COUNT_W'(held.size());
    beats_due.push_back(b);
    if (held.size() > peak_fill) peak_fill = held.size();
  endtask

  task automatic queue_cmd(input logic [CMD_W-1:0] cmd,
                           input logic signed [VAL_W-1:0] val);
    list_cmd_t c;
    c.cmd = cmd;
    c.value = val;
    cmd_q.push_back(c);
    items_queued++;
  endtask

  task automatic wait_drained();
    while (items_taken != items_queued || beats_due.size() != 0)
      @(negedge clk);
  endtask

  // input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // beat still waiting, hold it
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left = gap_left - 1;
    end else if (cmd_q.size() != 0) begin
      next_cmd = cmd_q.pop_front();
      in_valid <= 1'b1;
      in_cmd <= next_cmd.cmd;
      in_value <= next_cmd.value;
      gap_left = (calm_left > 0) ? 0 : pick_gap();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      stall_left = (calm_left > 0) ? 0 : pick_gap();
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    in_taken = 1'b0;
    if (rst_n) begin
      if (calm_left > 0) calm_left--;
      else if ($urandom_range(149) == 0) calm_left = 40;

      if (in_valid && !in_stall) begin
        in_taken = 1'b1;
        items_taken++;
        apply_list_cmd(in_cmd, in_value);
      end

      if (out_valid && !out_stall) begin
        beats_checked++;
        if (beats_due.size() == 0) begin
          $error("unexpected beat: status %0d item_value %0d count %0d last %0d",
                 out_status, out_item_value, out_count, out_last);
          mismatch_cnt++;
        end else begin
          want = beats_due.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            mismatch_cnt++;
          end
          if (out_item_value !== want.item_value) begin
            $error("item_value: expected %0d, got %0d", want.item_value, out_item_value);
            mismatch_cnt++;
          end
          if (out_count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, out_count);
            mismatch_cnt++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_last);
            mismatch_cnt++;
          end
        end
      end

      if (in_taken || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
      $display("FAIL ordered_list_engine_core");
      $finish;
    end
  end

  initial begin : stimulus
    bit filling;
    int phase_left;

    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // empty list corners
    queue_cmd(CMD_DUMP, '0);
    queue_cmd(CMD_DEL_FIRST, '0);
    queue_cmd(CMD_DEL_LAST, '0);
    queue_cmd(CMD_DEL_VALUE, VAL_MAX);
    // one entry, delete last leaves it empty
    queue_cmd(CMD_INSERT, VAL_MAX);
    queue_cmd(CMD_DEL_LAST, '0);
    // fill to the top with the extremes mixed in
    queue_cmd(CMD_INSERT, VAL_MIN);
    queue_cmd(CMD_INSERT, VAL_MAX);
    queue_cmd(CMD_INSERT, '0);
    queue_cmd(CMD_INSERT, -32'sd1);
    for (int i = 0; i < DEPTH - 4; i++)
      queue_cmd(CMD_INSERT, 32'sd1000 + i);
    queue_cmd(CMD_INSERT, 32'sh5A5A_5A5A);  // full, must be refused
    queue_cmd(CMD_DUMP, '0);
    queue_cmd(CMD_DEL_VALUE, VAL_MAX);       // hit next to the tail
    queue_cmd(CMD_DEL_VALUE, 32'sd77);       // miss
    queue_cmd(CMD_UNUSED_A, '0);
    queue_cmd(CMD_UNUSED_C, -32'sd1);

    wait_drained();

    filling = 1'b1;
    phase_left = 0;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (phase_left == 0) begin
        filling = !filling;
        phase_left = $urandom_range(15, 35);
      end
      phase_left--;
      if (n == 50 || n == 100) wait_drained();
      queue_cmd(pick_cmd(filling), pick_value());
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (beats_due.size() != 0) begin
      $error("%0d expected beats never arrived", beats_due.size());
      mismatch_cnt++;
    end

    $display("ran %0d commands (%0d dumps, %0d refused inserts), checked %0d result beats",
             items_taken, dump_cnt, full_hits, beats_checked);
    $display("list fill peaked at %0d of %0d entries", peak_fill, DEPTH);
    if (mismatch_cnt == 0) begin
      $display("PASS ordered_list_engine_core");
    end else begin
      $display("FAIL ordered_list_engine_core");
    end
    $finish;
  end

endmodule
